// File: rtl/core/bec_pkg.sv
// shared types and constants for the bounce easing curve unit
package bec_pkg;

  localparam int BEC_FRAC_BITS = 16;

  typedef enum logic [1:0] {
    MODE_IN     = 2'd0,
    MODE_OUT    = 2'd1,
    MODE_IN_OUT = 2'd2,
    MODE_OUT_IN = 2'd3
  } bec_mode_t;

  typedef enum logic {
    CFG_AMPLITUDE  = 1'b0,
    CFG_CURVE_MODE = 1'b1
  } bec_cfg_idx_t;

  // how the basic curve value is folded into the result
  typedef enum logic [1:0] {
    OP_PASS     = 2'd0,
    OP_SUB_ONE  = 2'd1,
    OP_HALF_SUB = 2'd2,
    OP_HALF_ADD = 2'd3
  } bec_op_t;

  typedef struct packed {
    bec_op_t op;
    logic    half_c;
  } bec_ctrl_t;

endpackage

// File: rtl/core/bounce_easing_curve_unit.sv
// top level of the bounce easing curve unit
// throughput: one sample per cycle while the output is not stalled, through a seven-stage evaluation pipeline
// an output stall freezes the pipeline; the two-entry queue absorbs the front end
// reset: amplitude returns to 1.0, curve mode to ease out, queue and pipeline empty
module bounce_easing_curve_unit
  import bec_pkg::*;
#(
  parameter int FRAC_BITS = BEC_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [FRAC_BITS+1:0]        cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [FRAC_BITS:0]          time_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [FRAC_BITS+1:0] eased_value
);

  logic [FRAC_BITS+1:0] amplitude;
  bec_mode_t            curve_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude  <= (FRAC_BITS + 2)'(1) << FRAC_BITS;
      curve_mode <= MODE_OUT;
    end else if (cfg_we) begin
      unique case (bec_cfg_idx_t'(cfg_index))
        CFG_AMPLITUDE:  amplitude  <= cfg_data;
        CFG_CURVE_MODE: curve_mode <= bec_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  logic [FRAC_BITS:0] fx;
  bec_ctrl_t          fctrl;
  logic               full;
  logic               pop_ready;
  logic               head_valid;
  logic [FRAC_BITS:0] head_x;
  bec_ctrl_t          head_ctrl;

  assign in_stall = full;

  bec_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .time_sample (time_sample),
    .curve_mode  (curve_mode),
    .x           (fx),
    .ctrl        (fctrl)
  );

  bec_queue #(.FRAC_BITS(FRAC_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_x     (fx),
    .push_ctrl  (fctrl),
    .full       (full),
    .pop_ready  (pop_ready),
    .head_valid (head_valid),
    .head_x     (head_x),
    .head_ctrl  (head_ctrl)
  );

  bec_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .amplitude   (amplitude),
    .head_valid  (head_valid),
    .head_x      (head_x),
    .head_ctrl   (head_ctrl),
    .pop_ready   (pop_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .eased_value (eased_value)
  );

endmodule

// File: rtl/core/bec_front.sv
// front end: time saturation and mode classification into curve argument and fold op
module bec_front
  import bec_pkg::*;
#(
  parameter int FRAC_BITS = BEC_FRAC_BITS
) (
  input  logic [FRAC_BITS:0] time_sample,
  input  bec_mode_t          curve_mode,
  output logic [FRAC_BITS:0] x,
  output bec_ctrl_t          ctrl
);

  localparam int XW = FRAC_BITS + 1;
  localparam logic [XW-1:0] ONE  = XW'(1) << FRAC_BITS;
  localparam logic [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);
  localparam logic [XW:0]   ONE_W = (XW + 1)'(1) << FRAC_BITS;
  localparam logic [XW:0]   TWO_W = (XW + 1)'(1) << (FRAC_BITS + 1);

  logic [XW-1:0] t_sat;
  logic [XW:0]   t2;
  logic          low_half;

  always_comb begin
    t_sat    = (time_sample > ONE) ? ONE : time_sample;
    t2       = {t_sat, 1'b0};
    low_half = (t_sat < HALF);
    x        = '0;
    ctrl     = '{op: OP_PASS, half_c: 1'b0};
    unique case (curve_mode)
      MODE_IN: begin
        x       = ONE - t_sat;
        ctrl.op = OP_SUB_ONE;
      end
      MODE_OUT: begin
        x       = t_sat;
        ctrl.op = OP_PASS;
      end
      MODE_IN_OUT: begin
        if (low_half) begin
          x       = XW'(ONE_W - t2);
          ctrl.op = OP_HALF_SUB;
        end else begin
          x       = XW'(t2 - ONE_W);
          ctrl.op = OP_HALF_ADD;
        end
      end
      MODE_OUT_IN: begin
        ctrl.half_c = 1'b1;
        if (low_half) begin
          x       = XW'(t2);
          ctrl.op = OP_PASS;
        end else begin
          x       = XW'(TWO_W - t2);
          ctrl.op = OP_SUB_ONE;
        end
      end
      default: begin
        x    = '0;
        ctrl = '{op: OP_PASS, half_c: 1'b0};
      end
    endcase
  end

endmodule

// File: rtl/core/bec_queue.sv
// two-entry queue between front end and evaluation pipeline
module bec_queue
  import bec_pkg::*;
#(
  parameter int FRAC_BITS = BEC_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [FRAC_BITS:0] push_x,
  input  bec_ctrl_t          push_ctrl,
  output logic               full,
  input  logic               pop_ready,
  output logic               head_valid,
  output logic [FRAC_BITS:0] head_x,
  output bec_ctrl_t          head_ctrl
);

  logic               tail_valid;
  logic [FRAC_BITS:0] tail_x;
  bec_ctrl_t          tail_ctrl;
  logic               pop;
  logic               do_push;

  assign full    = tail_valid;
  assign pop     = pop_ready && head_valid;
  assign do_push = push && !tail_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (pop) begin
      if (tail_valid) begin
        head_x     <= tail_x;
        head_ctrl  <= tail_ctrl;
        tail_valid <= 1'b0;
      end else if (do_push) begin
        head_x    <= push_x;
        head_ctrl <= push_ctrl;
      end else begin
        head_valid <= 1'b0;
      end
    end else if (do_push) begin
      if (head_valid) begin
        tail_x     <= push_x;
        tail_ctrl  <= push_ctrl;
        tail_valid <= 1'b1;
      end else begin
        head_x     <= push_x;
        head_ctrl  <= push_ctrl;
        head_valid <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/bec_back.sv
// evaluation pipeline: segment select, square, dip scaling, fold and saturation
module bec_back
  import bec_pkg::*;
#(
  parameter int FRAC_BITS = BEC_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [FRAC_BITS+1:0]       amplitude,
  input  logic                       head_valid,
  input  logic [FRAC_BITS:0]         head_x,
  input  bec_ctrl_t                  head_ctrl,
  output logic                       pop_ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [FRAC_BITS+1:0] eased_value
);

  localparam int FB  = FRAC_BITS;
  localparam int XW  = FB + 1;
  localparam int X11W = FB + 4;
  localparam int X22W = FB + 5;
  localparam int PW  = FB + 4;
  localparam int AW  = FB + 2;
  localparam int YW  = FB + 4;
  localparam int OW  = FB + 2;

  localparam logic [XW-1:0]   ONE_X  = XW'(1) << FB;
  localparam logic [X11W-1:0] SEG_4  = X11W'(4) << FB;
  localparam logic [X11W-1:0] SEG_8  = X11W'(8) << FB;
  localparam logic [X11W-1:0] SEG_10 = X11W'(10) << FB;
  localparam logic [X22W-1:0] MID_12 = X22W'(12) << FB;
  localparam logic [X22W-1:0] MID_18 = X22W'(18) << FB;
  localparam logic [X22W-1:0] MID_21 = X22W'(21) << FB;
  localparam logic [X22W-1:0] R_4    = X22W'(4) << FB;
  localparam logic [X22W-1:0] R_2    = X22W'(2) << FB;
  localparam logic [X22W-1:0] R_1    = X22W'(1) << FB;
  localparam logic signed [YW-1:0] ONE_Y  = YW'(1) << FB;
  localparam logic signed [YW-1:0] HALF_Y = YW'(1) << (FB - 1);
  localparam logic signed [YW-1:0] LIM_Y  = YW'(1) << (FB + 1);
  localparam logic signed [YW-1:0] MAX_Y  = LIM_Y - YW'(1);
  localparam logic signed [YW-1:0] MIN_Y  = -LIM_Y;

  // segment 0 is the rising parabola, 1..3 are the rebound dips
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_DIP4 = 2'd1,
    SEG_DIP2 = 2'd2,
    SEG_DIP1 = 2'd3
  } seg_t;

  logic en;
  assign en        = !out_valid || !out_stall;
  assign pop_ready = en;

  // stage 1
  logic            v1, top1;
  logic [X11W-1:0] x11_1;
  seg_t            seg1;
  bec_ctrl_t       ctrl1;
  logic [X11W-1:0] x11_c;
  seg_t            seg_c;

  always_comb begin
    x11_c = X11W'({head_x, 3'b000}) + X11W'({head_x, 1'b0}) + X11W'(head_x);
    priority if (x11_c < SEG_4) seg_c = SEG_RISE;
    else if (x11_c < SEG_8)     seg_c = SEG_DIP4;
    else if (x11_c < SEG_10)    seg_c = SEG_DIP2;
    else                        seg_c = SEG_DIP1;
  end

  // stage 2
  logic            v2, top2;
  logic [PW-1:0]   p2, q2;
  seg_t            seg2;
  bec_ctrl_t       ctrl2;
  logic [X22W-1:0] x22_c, mid_c, rone_c, w_c;

  always_comb begin
    x22_c = {x11_1, 1'b0};
    unique case (seg1)
      SEG_DIP4: begin mid_c = MID_12; rone_c = R_4; end
      SEG_DIP2: begin mid_c = MID_18; rone_c = R_2; end
      default:  begin mid_c = MID_21; rone_c = R_1; end
    endcase
    w_c = (x22_c >= mid_c) ? (x22_c - mid_c) : (mid_c - x22_c);
    if (w_c > rone_c) w_c = rone_c;
  end

  // stage 3
  logic            v3, top3;
  logic [2*PW-1:0] prod3;
  seg_t            seg3;
  bec_ctrl_t       ctrl3;

  // stage 4
  logic            v4, top4;
  logic [FB-1:0]   res4;
  seg_t            seg4;
  bec_ctrl_t       ctrl4;
  logic [2*PW-1:0] rise_c;

  always_comb begin
    rise_c = ctrl3.half_c ? (prod3 >> (FB + 5)) : (prod3 >> (FB + 4));
  end

  // stage 5
  logic              v5, top5;
  logic [AW+FB-1:0]  prod5;
  logic [FB-1:0]     res5;
  seg_t              seg5;
  bec_ctrl_t         ctrl5;

  // stage 6
  logic              v6;
  logic signed [YW-1:0] b6;
  bec_ctrl_t         ctrl6;
  logic signed [YW-1:0] c_c, drop_c, b_c;

  always_comb begin
    c_c    = ctrl5.half_c ? (ONE_Y >>> 1) : ONE_Y;
    drop_c = YW'(prod5[FB +: AW]);
    priority if (top5)          b_c = c_c;
    else if (seg5 == SEG_RISE)  b_c = YW'(res5);
    else                        b_c = c_c - drop_c;
  end

  // stage 7 fold and saturate
  logic signed [YW-1:0] y_c;

  always_comb begin
    unique case (ctrl6.op)
      OP_PASS:     y_c = b6;
      OP_SUB_ONE:  y_c = ONE_Y - b6;
      OP_HALF_SUB: y_c = (ONE_Y - b6) >>> 1;
      OP_HALF_ADD: y_c = (b6 >>> 1) + HALF_Y;
      default:     y_c = b6;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= head_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x11_1 <= x11_c;
      seg1  <= seg_c;
      top1  <= (head_x >= ONE_X);
      ctrl1 <= head_ctrl;

      if (seg1 == SEG_RISE) begin
        p2 <= PW'(x11_1);
        q2 <= PW'(x11_1);
      end else begin
        p2 <= PW'(rone_c - w_c);
        q2 <= PW'(rone_c + w_c);
      end
      seg2  <= seg1;
      top2  <= top1;
      ctrl2 <= ctrl1;

      prod3 <= {{PW{1'b0}}, p2} * {{PW{1'b0}}, q2};
      seg3  <= seg2;
      top3  <= top2;
      ctrl3 <= ctrl2;

      res4  <= (seg3 == SEG_RISE) ? FB'(rise_c) : FB'(prod3 >> (FB + 6));
      seg4  <= seg3;
      top4  <= top3;
      ctrl4 <= ctrl3;

      prod5 <= {{FB{1'b0}}, amplitude} * {{AW{1'b0}}, res4};
      res5  <= res4;
      seg5  <= seg4;
      top5  <= top4;
      ctrl5 <= ctrl4;

      b6    <= b_c;
      ctrl6 <= ctrl5;

      if (y_c > MAX_Y)      eased_value <= OW'(MAX_Y);
      else if (y_c < MIN_Y) eased_value <= OW'(MIN_Y);
      else                  eased_value <= OW'(y_c);
    end
  end

endmodule

// File: verif/tb_bounce_easing_curve_unit.sv
// self-checking testbench for the bounce easing curve unit
module tb_bounce_easing_curve_unit
  import bec_pkg::*;
();

  localparam int FB = BEC_FRAC_BITS;
  localparam longint UNIT = longint'(1) << FB;
  localparam longint HALF = UNIT >> 1;
  localparam longint Y_MAX = (longint'(1) << (FB + 1)) - 1;
  localparam longint Y_MIN = -(longint'(1) << (FB + 1));
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    bec_mode_t          mode;
    logic [FB+1:0]      amp;
    logic [FB:0]        t;
    bit                 fixed;
    logic signed [FB+1:0] val;
  } sample_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [FB+1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FB:0]          time_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [FB+1:0] eased_value;

  logic signed [FB+1:0] eased_q[$];
  logic [FB+1:0]        amp_reg;
  bec_mode_t            mode_reg;
  int                   fail_count = 0;
  int                   results_seen = 0;
  int                   sent_count = 0;
  int                   idle_cycles = 0;
  bit                   hold_done = 1'b0;

  bounce_easing_curve_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .time_sample(time_sample),
    .out_valid(out_valid), .out_stall(out_stall), .eased_value(eased_value)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // basic bounce shape, peak value UNIT >> cshift
  function automatic longint bounce_shape(longint x, int cshift, longint amp);
    longint c, x11, w, r, m, dip, drop;
    c = UNIT >> cshift;
    if (x >= UNIT) return c;
    x11 = 11 * x;
    if (x11 < 4 * UNIT) return (x11 * x11) >> (FB + 4 + cshift);
    if (x11 < 8 * UNIT) begin
      m = 12; r = 4;
    end else if (x11 < 10 * UNIT) begin
      m = 18; r = 2;
    end else begin
      m = 21; r = 1;
    end
    w = 2 * x11 - m * UNIT;
    if (w < 0) w = -w;
    if (w > r * UNIT) w = r * UNIT;
    dip = ((r * UNIT - w) * (r * UNIT + w)) >> (FB + 6);
    drop = (amp * dip) >> FB;
    return c - drop;
  endfunction

  function automatic logic signed [FB+1:0] predict_eased(logic [FB:0] t_in, bec_mode_t mode,
                                                         logic [FB+1:0] amp_in);
    longint t, amp, y;
    t = t_in;
    amp = amp_in;
    if (t > UNIT) t = UNIT;
    case (mode)
      MODE_IN: y = UNIT - bounce_shape(UNIT - t, 0, amp);
      MODE_OUT: y = bounce_shape(t, 0, amp);
      MODE_IN_OUT: begin
        if (t < HALF) y = (UNIT - bounce_shape(UNIT - 2 * t, 0, amp)) >>> 1;
        else if (t == UNIT) y = UNIT;
        else y = (bounce_shape(2 * t - UNIT, 0, amp) >>> 1) + HALF;
      end
      default: begin
        if (t < HALF) y = bounce_shape(2 * t, 1, amp);
        else y = UNIT - bounce_shape(2 * UNIT - 2 * t, 1, amp);
      end
    endcase
    if (y > Y_MAX) y = Y_MAX;
    if (y < Y_MIN) y = Y_MIN;
    return y[FB+1:0];
  endfunction

  function automatic int pick_gap(int idx);
    int r;
    r = $urandom_range(0, 99);
    if ((idx / 60) % 4 == 2) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [FB:0] pick_time();
    int bp[7] = '{23831, 47662, 59578, 32768, 35747, 53620, 62557};
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return (FB + 1)'($urandom_range(0, int'(UNIT)));
    if (r < 80) return (FB + 1)'(bp[$urandom_range(0, 6)] + int'($urandom_range(0, 6)) - 3);
    if (r < 92) return (FB + 1)'($urandom_range(int'(UNIT) + 1, (1 << (FB + 1)) - 1));
    case ($urandom_range(0, 2))
      0: return '0;
      1: return (FB + 1)'(UNIT);
      default: return (FB + 1)'(HALF);
    endcase
  endfunction

  // registers change only once every result is back
  task automatic write_reg(bec_cfg_idx_t idx, logic [FB+1:0] d);
    in_valid <= 1'b0;
    while (eased_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AMPLITUDE) amp_reg = d;
    else mode_reg = bec_mode_t'(d[1:0]);
  endtask

  task automatic send_sample(logic [FB:0] t, bit fixed, logic signed [FB+1:0] val);
    int gap;
    gap = pick_gap(sent_count);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    time_sample <= t;
    do @(posedge clk); while (in_stall);
    eased_q.push_back(fixed ? val : predict_eased(t, mode_reg, amp_reg));
    sent_count++;
  endtask

  sample_row_t rows[] = '{
    '{MODE_OUT, 18'd65536, 17'd0, 1, 18'sd0},
    '{MODE_OUT, 18'd65536, 17'd65536, 1, 18'sd65536},
    '{MODE_OUT, 18'd65536, 17'd131071, 1, 18'sd65536},
    '{MODE_OUT, 18'd65536, 17'd23831, 0, 18'sd0},
    '{MODE_OUT, 18'd65536, 17'd23832, 0, 18'sd0},
    '{MODE_OUT, 18'd65536, 17'd47662, 0, 18'sd0},
    '{MODE_OUT, 18'd65536, 17'd59578, 0, 18'sd0},
    '{MODE_OUT, 18'd65536, 17'd62557, 0, 18'sd0},
    '{MODE_OUT, 18'd262143, 17'd35747, 0, 18'sd0},
    '{MODE_OUT, 18'd0, 17'd35747, 1, 18'sd65536},
    '{MODE_IN, 18'd0, 17'd29789, 0, 18'sd0},
    '{MODE_IN, 18'd262143, 17'd29789, 0, 18'sd0},
    '{MODE_IN, 18'd65536, 17'd0, 1, 18'sd0},
    '{MODE_IN, 18'd65536, 17'd65536, 1, 18'sd65536},
    '{MODE_IN, 18'd65536, 17'd32768, 0, 18'sd0},
    '{MODE_IN_OUT, 18'd65536, 17'd0, 1, 18'sd0},
    '{MODE_IN_OUT, 18'd65536, 17'd32767, 0, 18'sd0},
    '{MODE_IN_OUT, 18'd65536, 17'd32768, 0, 18'sd0},
    '{MODE_IN_OUT, 18'd65536, 17'd65535, 0, 18'sd0},
    '{MODE_IN_OUT, 18'd65536, 17'd65536, 1, 18'sd65536},
    '{MODE_OUT_IN, 18'd65536, 17'd0, 1, 18'sd0},
    '{MODE_OUT_IN, 18'd65536, 17'd32767, 0, 18'sd0},
    '{MODE_OUT_IN, 18'd65536, 17'd32768, 0, 18'sd0},
    '{MODE_OUT_IN, 18'd65536, 17'd65536, 1, 18'sd65536}
  };

  initial begin
    logic [FB+1:0] amp;
    amp_reg = (FB + 2)'(UNIT);
    mode_reg = MODE_OUT;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].amp != amp_reg) write_reg(CFG_AMPLITUDE, rows[i].amp);
      if (rows[i].mode != mode_reg)
        write_reg(CFG_CURVE_MODE, {FB'($urandom_range(0, 65535)), rows[i].mode});
      send_sample(rows[i].t, rows[i].fixed, rows[i].val);
    end
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: amp = '0;
        1: amp = '1;
        2: amp = (FB + 2)'(UNIT);
        3: amp = (FB + 2)'(HALF);
        default: amp = (FB + 2)'($urandom_range(0, (1 << (FB + 2)) - 1));
      endcase
      write_reg(CFG_AMPLITUDE, amp);
      write_reg(CFG_CURVE_MODE, {FB'($urandom_range(0, 65535)), 2'(ph % 4)});
      repeat (75) send_sample(pick_time(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (eased_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** bounce_easing_curve_unit: PASSED **");
    end else begin
      $display("** bounce_easing_curve_unit: FAILED **");
    end
    $finish;
  end

  // output stall, with calm stretches and one long hold-off
  initial begin
    int n;
    forever begin
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        n = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if ((results_seen / 100) % 3 == 1) begin
        n = 1;
        out_stall <= 1'b0;
      end else begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    logic signed [FB+1:0] want;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (eased_q.size() == 0) begin
        $error("eased_value %0d transferred with nothing expected", eased_value);
        fail_count++;
      end else begin
        want = eased_q.pop_front();
        if (eased_value !== want) begin
          $error("eased_value: expected %0d, actual %0d", want, eased_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** bounce_easing_curve_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
